/* src/lspt_pkg.sv */
// ----------------------------------------------------------------------------
// lspt_pkg
// Shared types and constants for the learning switch port table.
// ----------------------------------------------------------------------------
`default_nettype none

package lspt_pkg;

    localparam int MASK_W      = 8;
    localparam int PORT_FIELD_W = 3;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0] PORT_COUNT_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lspt_state_t;

    typedef struct packed {
        logic [MASK_W-1:0] out_mask;
        logic              flooded;
        logic              learned;
    } lspt_result_t;

endpackage

`default_nettype wire

/* src/lspt_slot_mem.sv */
// ----------------------------------------------------------------------------
// lspt_slot_mem
// Slot storage: learned addresses in a synchronous memory, valid bits in
// flip-flops cleared by reset. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lspt_slot_mem #(
    parameter int NUM_PORTS = 8,
    parameter int ADDR_BITS = 8,
    parameter int PW        = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [PW-1:0]        rd_idx,
    output logic                      rd_valid,
    output logic [ADDR_BITS-1:0]      rd_addr,
    input  wire logic                 wr_en,
    input  wire logic [PW-1:0]        wr_idx,
    input  wire logic [ADDR_BITS-1:0] wr_addr
);

    logic [ADDR_BITS-1:0] slot_addr_mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] slot_vld_reg;
    logic                 rd_vld_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_addr_mem[wr_idx] <= wr_addr;
        end
        if (rd_en)
        begin
            rd_addr_reg <= slot_addr_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= slot_vld_reg[rd_idx];
            end
        end
    end

    assign rd_valid = rd_vld_reg;
    assign rd_addr  = rd_addr_reg;

endmodule

`default_nettype wire

/* src/lspt_ctrl.sv */
// ----------------------------------------------------------------------------
// lspt_ctrl
// Scan sequencer: walks the slots once per header, matching source and
// destination together, then learns the source and builds the port mask.
// ----------------------------------------------------------------------------
`default_nettype none

module lspt_ctrl
    import lspt_pkg::*;
#(
    parameter int NUM_PORTS = 8,
    parameter int ADDR_BITS = 8,
    parameter int PW        = 3,
    parameter int CW        = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              src_addr,
    input  wire logic [7:0]              dst_addr,
    input  wire logic [PORT_FIELD_W-1:0] in_port,
    input  wire logic [CFG_W-1:0]        port_count,
    output logic                         rd_en,
    output logic [PW-1:0]                rd_idx,
    input  wire logic                    rd_valid,
    input  wire logic [ADDR_BITS-1:0]    rd_addr,
    output logic                         wr_en,
    output logic [PW-1:0]                wr_idx,
    output logic [ADDR_BITS-1:0]         wr_addr,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output lspt_result_t                 res
);

    localparam int CMPW = (PW > PORT_FIELD_W) ? PW : PORT_FIELD_W;
    localparam logic [CW-1:0]   LAST_CNT = CW'(NUM_PORTS);
    localparam logic [CMPW:0]   NP_CMP   = (CMPW+1)'(NUM_PORTS);

    lspt_state_t state_reg, state_next;

    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    proc_vld_reg, proc_vld_next;
    logic [PW-1:0]           proc_idx_reg, proc_idx_next;
    logic [ADDR_BITS-1:0]    src_reg, src_next;
    logic [ADDR_BITS-1:0]    dst_reg, dst_next;
    logic [PORT_FIELD_W-1:0] port_reg, port_next;
    logic                    src_found_reg, src_found_next;
    logic                    all_found_reg, all_found_next;
    logic [PW-1:0]           all_idx_reg, all_idx_next;
    logic                    excl_found_reg, excl_found_next;
    logic [PW-1:0]           excl_idx_reg, excl_idx_next;

    logic            accept;
    logic            scan_done;
    logic            hit_src;
    logic            hit_dst;
    logic            proc_is_port;
    logic            port_in_range;
    logic            learn;
    logic            self_hit;
    logic            found;
    logic [PW-1:0]   hit_idx;
    logic [MASK_W-1:0] mask;

    assign accept    = in_valid && !in_stall;
    assign scan_done = (cnt_reg == LAST_CNT) && !proc_vld_reg;

    assign hit_src      = proc_vld_reg && rd_valid && (rd_addr == src_reg);
    assign hit_dst      = proc_vld_reg && rd_valid && (rd_addr == dst_reg);
    assign proc_is_port = (CMPW'(proc_idx_reg) == CMPW'(port_reg));

    assign port_in_range = ({1'b0, CMPW'(port_reg)} < NP_CMP);
    assign learn         = !src_found_reg && port_in_range;

    // A freshly learned slot holds the source, so the arrival port's old
    // contents take no part in the lookup when learning happens.
    always_comb
    begin
        self_hit = learn && (src_reg == dst_reg);
        if (learn)
        begin
            found = self_hit || excl_found_reg;
            if (self_hit && (!excl_found_reg || (CMPW'(port_reg) < CMPW'(excl_idx_reg))))
            begin
                hit_idx = PW'(port_reg);
            end
            else
            begin
                hit_idx = excl_idx_reg;
            end
        end
        else
        begin
            found   = all_found_reg;
            hit_idx = all_idx_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < MASK_W; k++)
        begin
            if (found)
            begin
                mask[k] = (k < NUM_PORTS) && (CMPW'(hit_idx) == CMPW'(k));
            end
            else
            begin
                mask[k] = (k < NUM_PORTS) && (CFG_W'(k) < port_count)
                          && (CMPW'(port_reg) != CMPW'(k));
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall  = 1'b1;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = (cnt_reg != LAST_CNT);
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                wr_en     = learn && res_ready;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign rd_idx  = cnt_reg[PW-1:0];
    assign wr_idx  = PW'(port_reg);
    assign wr_addr = src_reg;

    assign res.out_mask = mask;
    assign res.flooded  = !found;
    assign res.learned  = learn;

    // Scan datapath
    always_comb
    begin
        cnt_next        = cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        port_next       = port_reg;
        src_found_next  = src_found_reg;
        all_found_next  = all_found_reg;
        all_idx_next    = all_idx_reg;
        excl_found_next = excl_found_reg;
        excl_idx_next   = excl_idx_reg;

        if (accept)
        begin
            cnt_next        = '0;
            src_next        = ADDR_BITS'(src_addr);
            dst_next        = ADDR_BITS'(dst_addr);
            port_next       = in_port;
            src_found_next  = 1'b0;
            all_found_next  = 1'b0;
            excl_found_next = 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (rd_en)
            begin
                cnt_next      = cnt_reg + 1'b1;
                proc_vld_next = 1'b1;
                proc_idx_next = cnt_reg[PW-1:0];
            end
            if (hit_src)
            begin
                src_found_next = 1'b1;
            end
            // Slots arrive in ascending order, so the first hit is the lowest.
            if (hit_dst && !all_found_reg)
            begin
                all_found_next = 1'b1;
                all_idx_next   = proc_idx_reg;
            end
            if (hit_dst && !proc_is_port && !excl_found_reg)
            begin
                excl_found_next = 1'b1;
                excl_idx_next   = proc_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            proc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            proc_vld_reg <= proc_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        port_reg       <= port_next;
        src_found_reg  <= src_found_next;
        all_found_reg  <= all_found_next;
        all_idx_reg    <= all_idx_next;
        excl_found_reg <= excl_found_next;
        excl_idx_reg   <= excl_idx_next;
    end

endmodule

`default_nettype wire

/* src/learning_switch_port_table.sv */
// ----------------------------------------------------------------------------
// learning_switch_port_table
// Learning switch with one address slot per port, producing a port mask.
// ----------------------------------------------------------------------------
// The slot memory has one read port and is walked once per header,
// checking source and destination on the same read, and a final step
// learns the source and hands the result to the output register. A new
// header is accepted once the previous result has moved into the output
// register, even if the downstream side is still stalling it. Slot valid
// bits clear at reset, so no clearing pass is needed.
// port_count may be written whenever cfg_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module learning_switch_port_table
    import lspt_pkg::*;
#(
    parameter int NUM_PORTS = 8,
    parameter int ADDR_BITS = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              src_addr,
    input  wire logic [7:0]              dst_addr,
    input  wire logic [PORT_FIELD_W-1:0] in_port,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [MASK_W-1:0]            out_mask,
    output logic                         flooded,
    output logic                         learned,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    localparam int PW = $clog2(NUM_PORTS);
    localparam int CW = $clog2(NUM_PORTS + 1);

    logic [CFG_W-1:0]     port_count_reg, port_count_next;
    logic                 out_vld_reg, out_vld_next;
    lspt_result_t         out_res_reg, out_res_next;

    logic                 rd_en;
    logic [PW-1:0]        rd_idx;
    logic                 rd_valid;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [PW-1:0]        wr_idx;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 res_valid;
    logic                 res_ready;
    lspt_result_t         res;

    lspt_slot_mem #(
        .NUM_PORTS (NUM_PORTS),
        .ADDR_BITS (ADDR_BITS),
        .PW        (PW)
    ) u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_valid (rd_valid),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_addr  (wr_addr)
    );

    lspt_ctrl #(
        .NUM_PORTS (NUM_PORTS),
        .ADDR_BITS (ADDR_BITS),
        .PW        (PW),
        .CW        (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .src_addr   (src_addr),
        .dst_addr   (dst_addr),
        .in_port    (in_port),
        .port_count (port_count_reg),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_valid   (rd_valid),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_addr    (wr_addr),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !out_vld_reg || !out_stall;

    always_comb
    begin
        port_count_next = port_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            port_count_next = cfg_data;
        end
    end

    // The output register frees up in the same cycle its beat is taken.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (res_ready)
        begin
            out_vld_next = res_valid;
            out_res_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= PORT_COUNT_RESET;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            port_count_reg <= port_count_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_vld_reg;
    assign out_mask  = out_res_reg.out_mask;
    assign flooded   = out_res_reg.flooded;
    assign learned   = out_res_reg.learned;

endmodule

`default_nettype wire

/* dv/lspt_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lspt_scoreboard_pkg
// Forwarding predictor and result checker for the learning switch port table.
// ----------------------------------------------------------------------------
package lspt_scoreboard_pkg;

    import lspt_pkg::*;

    localparam int TABLE_SLOTS = 8;

    class forward_scoreboard;

        bit                 slot_valid [TABLE_SLOTS];
        logic [7:0]         slot_addr  [TABLE_SLOTS];
        logic [CFG_W-1:0]   port_count;
        lspt_result_t       pending_masks [$];
        int unsigned        mismatches;

        function new();
            foreach (slot_valid[i])
            begin
                slot_valid[i] = 1'b0;
                slot_addr[i]  = 8'h00;
            end
            port_count = PORT_COUNT_RESET;
            mismatches = 0;
        endfunction

        function void set_port_count(logic [CFG_W-1:0] value);
            port_count = value;
        endfunction

        // Returns TABLE_SLOTS when no valid slot holds the address.
        function int lowest_slot(logic [7:0] addr);
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (slot_valid[i] && slot_addr[i] == addr)
                    return i;
            end
            return TABLE_SLOTS;
        endfunction

        function void note_header(logic [7:0] src, logic [7:0] dst,
                                  logic [PORT_FIELD_W-1:0] port);
            lspt_result_t fwd;
            int           hit;
            int           used;
            fwd = '0;
            // Learning comes first, so a header can hit on its own source.
            if (lowest_slot(src) == TABLE_SLOTS)
            begin
                slot_valid[port] = 1'b1;
                slot_addr[port]  = src;
                fwd.learned      = 1'b1;
            end
            hit = lowest_slot(dst);
            if (hit < TABLE_SLOTS)
                fwd.out_mask[hit] = 1'b1;
            else
            begin
                fwd.flooded = 1'b1;
                used = (port_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(port_count);
                for (int k = 0; k < used; k++)
                begin
                    if (k != int'(port))
                        fwd.out_mask[k] = 1'b1;
                end
            end
            pending_masks.push_back(fwd);
        endfunction

        function void check_mask(logic [MASK_W-1:0] mask, logic flood, logic learn);
            lspt_result_t want;
            if (pending_masks.size() == 0)
            begin
                $error("result beat with nothing pending: out_mask %h flooded %b learned %b",
                       mask, flood, learn);
                mismatches++;
                return;
            end
            want = pending_masks.pop_front();
            if (mask !== want.out_mask)
            begin
                $error("out_mask: expected %h, actual %h", want.out_mask, mask);
                mismatches++;
            end
            if (flood !== want.flooded)
            begin
                $error("flooded: expected %b, actual %b", want.flooded, flood);
                mismatches++;
            end
            if (learn !== want.learned)
            begin
                $error("learned: expected %b, actual %b", want.learned, learn);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* dv/learning_switch_port_table_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// learning_switch_port_table_test
// Drives packet headers and port_count writes into the port table and checks
// every result beat against a predicted mask, under random idling on both
// sides, a long output hold-off and several port counts.
// ----------------------------------------------------------------------------
module learning_switch_port_table_test;

    import lspt_pkg::*;
    import lspt_scoreboard_pkg::*;

    localparam int PHASES         = 12;
    localparam int PHASE_HEADERS  = 155;
    localparam int POOL_SIZE      = 12;
    localparam int SETTLE_CYCLES  = 16;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [7:0]              src_addr  = 8'h00;
    logic [7:0]              dst_addr  = 8'h00;
    logic [PORT_FIELD_W-1:0] in_port   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [MASK_W-1:0]       out_mask;
    logic                    flooded;
    logic                    learned;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data  = '0;

    forward_scoreboard sb = new();

    bit          sender_idle   = 1'b0;
    bit          receiver_idle = 1'b0;
    int unsigned long_hold     = 0;
    logic [7:0]  addr_pool [POOL_SIZE];

    logic [CFG_W-1:0] phase_count [PHASES] =
        '{4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd0, 4'd15, 4'd9, 4'd8};

    learning_switch_port_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr),
        .in_port   (in_port),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_mask  (out_mask),
        .flooded   (flooded),
        .learned   (learned),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic send_header(input logic [7:0] src, input logic [7:0] dst,
                               input logic [PORT_FIELD_W-1:0] port);
        int gap;
        gap = sender_idle ? $urandom_range(5, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        src_addr <= src;
        dst_addr <= dst;
        in_port  <= port;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_header(src, dst, port);
    endtask

    // Lowers valid and waits until every predicted beat has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_masks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_port_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_port_count(value);
    endtask

    task automatic send_pool_header();
        logic [7:0] src;
        logic [7:0] dst;
        // Mostly addresses from a small pool, so lookups hit learned slots.
        src = ($urandom_range(3, 0) == 0) ? 8'($urandom) : addr_pool[$urandom_range(POOL_SIZE - 1, 0)];
        dst = ($urandom_range(3, 0) == 0) ? 8'($urandom) : addr_pool[$urandom_range(POOL_SIZE - 1, 0)];
        send_header(src, dst, PORT_FIELD_W'($urandom));
    endtask

    // Output side: random stall before each beat, or a long hold when asked.
    initial
    begin
        int unsigned n;
        @(posedge rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                n = long_hold;
                long_hold = 0;
            end
            else
                n = receiver_idle ? $urandom_range(5, 0) : 0;
            out_stall <= (n > 0);
            if (n > 0)
            begin
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_mask(out_mask, flooded, learned);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed headers at the reset port count of eight.
        send_header(8'h00, 8'h00, 3'd0);
        send_header(8'hFF, 8'hFF, 3'd7);
        send_header(8'h00, 8'hFF, 3'd3);
        send_header(8'h0C, 8'h63, 3'd7);
        send_header(8'h0C, 8'h0C, 3'd2);
        send_header(8'hFF, 8'h00, 3'd5);
        send_header(8'h4D, 8'hFF, 3'd0);
        send_header(8'hAA, 8'h55, 3'd4);

        // No ports in use: a flood sends nowhere.
        write_port_count(4'd0);
        send_header(8'h11, 8'hEE, 3'd1);
        send_header(8'h11, 8'h0C, 3'd6);

        // Counts above the table saturate to the full table.
        write_port_count(4'd15);
        send_header(8'h22, 8'hDD, 3'd6);
        send_header(8'h22, 8'h22, 3'd6);

        // Arrival ports outside the ones in use still learn.
        write_port_count(4'd1);
        send_header(8'h33, 8'hCC, 3'd4);
        send_header(8'h44, 8'hCC, 3'd0);
        send_header(8'h44, 8'h33, 3'd0);

        write_port_count(4'd3);
        send_header(8'h5A, 8'hA5, 3'd6);
        send_header(8'h5B, 8'hA5, 3'd1);
        send_header(8'h01, 8'h5A, 3'd2);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_port_count(phase_count[phase]);
            foreach (addr_pool[i])
                addr_pool[i] = 8'($urandom);
            sender_idle   = (phase == 0) ? 1'b0 : 1'($urandom);
            receiver_idle = (phase == 0) ? 1'b0 : 1'($urandom);
            if (phase == 3)
            begin
                sender_idle   = 1'b1;
                receiver_idle = 1'b1;
            end
            for (int n = 0; n < PHASE_HEADERS; n++)
            begin
                // The output holds off while headers keep coming, filling the block.
                if ((phase == 1 || phase == 6) && n == 20)
                    long_hold = 300;
                if (n == 100)
                    drain_results();
                send_pool_header();
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_masks.size() == 0)
            $display("[learning_switch_port_table] OK");
        else
            $display("[learning_switch_port_table] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[learning_switch_port_table] ERROR");
        $finish;
    end

endmodule
